[hdl/m4xf_pkg.sv]
// Shared types, widths, command codes and matrix helpers for the 4x4 transform engine.
package m4xf_pkg;

    // Fixed-point format of every element, matrix entry and result component.
    localparam int FRAC_BITS = 16;
    localparam int FIX_W     = 32;
    localparam int PROD_W    = 2 * FIX_W;      // one full product
    localparam int PAIR_W    = PROD_W + 1;     // sum of two products
    localparam int ACC_W     = PROD_W + 2;     // sum of four products
    localparam int CMD_W     = 2;

    // Configuration register file: eight 64-bit words, two entries per word.
    localparam int NUM_CFG   = 8;
    localparam int CFG_SEL_W = $clog2(NUM_CFG);
    localparam int CFG_IDX_W = CFG_SEL_W + 1;  // one extra bit so out-of-range writes are seen
    localparam int CFG_W     = 2 * FIX_W;

    localparam logic [CMD_W-1:0] CMD_VEC4  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POINT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROW   = 2'd2;

    localparam logic [FIX_W-1:0] ONE_FIX  = FIX_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (FRAC_BITS - 1);

    typedef logic signed [FIX_W-1:0]  fix_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [CFG_W-1:0]         cfg_word_t;

    typedef cfg_word_t mat_regs_t [NUM_CFG];
    typedef fix_t      vec4_t     [4];
    typedef fix_t      mat4_t     [4][4];
    typedef prod_t     prod_mat_t [4][4];
    typedef pair_t     pair_mat_t [4][2];

    // Word index and half for matrix entry (row, col).
    function automatic fix_t mat_entry(input mat_regs_t regs, input int row, input int col);
        cfg_word_t w;
        w = regs[(row % 4) * 2 + ((col / 2) % 2)];
        return (col % 2 == 1) ? fix_t'(w[CFG_W-1:FIX_W]) : fix_t'(w[FIX_W-1:0]);
    endfunction

    // Reset contents of word idx: identity matrix.
    function automatic cfg_word_t mat_reset_word(input int idx);
        cfg_word_t w;
        int        r;
        w = '0;
        for (r = 0; r < 4; r++) begin
            if (r * 2 + (r / 2) == idx) begin
                if (r % 2 == 1) begin
                    w[CFG_W-1:FIX_W] = ONE_FIX;
                end else begin
                    w[FIX_W-1:0] = ONE_FIX;
                end
            end
        end
        return w;
    endfunction

endpackage

[hdl/matrix4_transform_engine.sv]
// Top level of the 4x4 matrix-vector transform engine: matrix registers and a four-stage pipeline.
//
//   channel   dir   handshake              payload
//   s_*       in    s_valid / s_ready      s_command, s_elem_0..s_elem_3
//   m_*       out   m_valid / m_ready      m_res_0..m_res_3, m_saturated
//   cfg_*     in    cfg_wr_en (no wait)    cfg_index, cfg_wdata
//
// An accepted input beat passes through the stage registers (operand select, multiply,
// pair add, final add with rounding and saturation) to a valid result beat; one beat
// enters every cycle while m_ready does not hold the pipeline.
// Each stage holds its own valid bit and loads whenever it is empty or its successor
// loads, so a stall on m_ready fills bubbles first and never drops or repeats a beat.
// Reset (aresetn low at a clock edge) empties the pipeline and loads the identity matrix.
module matrix4_transform_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [m4xf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [m4xf_pkg::CFG_W-1:0]      cfg_wdata,
    // input beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [m4xf_pkg::CMD_W-1:0]      s_command,
    input  logic signed [m4xf_pkg::FIX_W-1:0] s_elem_0,
    input  logic signed [m4xf_pkg::FIX_W-1:0] s_elem_1,
    input  logic signed [m4xf_pkg::FIX_W-1:0] s_elem_2,
    input  logic signed [m4xf_pkg::FIX_W-1:0] s_elem_3,
    // result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [m4xf_pkg::FIX_W-1:0] m_res_0,
    output logic signed [m4xf_pkg::FIX_W-1:0] m_res_1,
    output logic signed [m4xf_pkg::FIX_W-1:0] m_res_2,
    output logic signed [m4xf_pkg::FIX_W-1:0] m_res_3,
    output logic                            m_saturated
);
    import m4xf_pkg::*;

    // Matrix registers: the user must write them only while the pipeline is idle (the
    // block does not enforce this), so the operand stage can read them directly.
    mat_regs_t mat_reg;
    mat_regs_t mat_next;

    vec4_t     s_elem;
    logic      sel_valid;
    logic      sel_ready;
    mat4_t     sel_a;
    vec4_t     sel_v;
    logic      mul_valid;
    logic      mul_ready;
    prod_mat_t mul_prod;
    vec4_t     res;

    // Writes beyond the last register index are dropped.
    always_comb begin
        mat_next = mat_reg;
        if (cfg_wr_en && cfg_index < CFG_IDX_W'(NUM_CFG)) begin
            mat_next[cfg_index[CFG_SEL_W-1:0]] = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                mat_reg[i] <= mat_reset_word(i);
            end
        end else begin
            mat_reg <= mat_next;
        end
    end

    assign s_elem[0] = s_elem_0;
    assign s_elem[1] = s_elem_1;
    assign s_elem[2] = s_elem_2;
    assign s_elem[3] = s_elem_3;

    // Stage 1: command decode and operand routing.
    m4xf_operand_sel u_sel (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mat_regs   (mat_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_command (s_command),
        .in_elem    (s_elem),
        .out_valid  (sel_valid),
        .out_ready  (sel_ready),
        .out_a      (sel_a),
        .out_v      (sel_v)
    );

    // Stage 2: sixteen products.
    m4xf_mul_array u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_a      (sel_a),
        .in_v      (sel_v),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_prod  (mul_prod)
    );

    // Stages 3 and 4: reduce, round, saturate; stage 4 is the output register.
    m4xf_reduce u_red (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_prod   (mul_prod),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res),
        .out_sat   (m_saturated)
    );

    assign m_res_0 = res[0];
    assign m_res_1 = res[1];
    assign m_res_2 = res[2];
    assign m_res_3 = res[3];

`ifndef SYNTHESIS
    // A flagged result carries at least one clipped component.
    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_res_0 == 32'sh7fffffff || m_res_0 == 32'sh80000000 ||
             m_res_1 == 32'sh7fffffff || m_res_1 == 32'sh80000000 ||
             m_res_2 == 32'sh7fffffff || m_res_2 == 32'sh80000000 ||
             m_res_3 == 32'sh7fffffff || m_res_3 == 32'sh80000000))
        else $error("saturated flag without a clipped component");

    // An empty operand stage always takes a new beat.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !sel_valid |-> s_ready)
        else $error("input stalled with empty first stage");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

[hdl/m4xf_operand_sel.sv]
// Stage 1: register the vector and pick the matrix operands for each result lane.
module m4xf_operand_sel (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  m4xf_pkg::mat_regs_t         mat_regs,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [m4xf_pkg::CMD_W-1:0]  in_command,
    input  m4xf_pkg::vec4_t             in_elem,
    output logic                        out_valid,
    input  logic                        out_ready,
    output m4xf_pkg::mat4_t             out_a,
    output m4xf_pkg::vec4_t             out_v
);
    import m4xf_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    mat4_t a_reg;
    mat4_t a_next;
    vec4_t v_reg;
    vec4_t v_next;
    logic  load;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            v_next[k] = in_elem[k];
        end
        // point: w is one
        if (in_command == CMD_POINT) begin
            v_next[3] = fix_t'(ONE_FIX);
        end
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                if (in_command == CMD_ROW) begin
                    a_next[i][k] = mat_entry(mat_regs, k, i);
                end else if (in_command == CMD_POINT && i == 3) begin
                    a_next[i][k] = '0;
                end else begin
                    a_next[i][k] = mat_entry(mat_regs, i, k);
                end
            end
        end
        valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg <= a_next;
            v_reg <= v_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_v     = v_reg;

endmodule

[hdl/m4xf_mul_array.sv]
// Stage 2: sixteen 32x32 signed multipliers with registered products.
module m4xf_mul_array (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  m4xf_pkg::mat4_t       in_a,
    input  m4xf_pkg::vec4_t       in_v,
    output logic                  out_valid,
    input  logic                  out_ready,
    output m4xf_pkg::prod_mat_t   out_prod
);
    import m4xf_pkg::*;

    logic      valid_reg;
    prod_mat_t prod_reg;
    prod_mat_t prod_next;
    logic      load;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                prod_next[i][k] = prod_t'(in_a[i][k]) * prod_t'(in_v[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;

endmodule

[hdl/m4xf_reduce.sv]
// Stages 3 and 4: pairwise add, final add with round half up, saturate to 32 bits.
module m4xf_reduce (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  m4xf_pkg::prod_mat_t   in_prod,
    output logic                  out_valid,
    input  logic                  out_ready,
    output m4xf_pkg::vec4_t       out_res,
    output logic                  out_sat
);
    import m4xf_pkg::*;

    logic      pair_valid_reg;
    pair_mat_t pair_reg;
    pair_mat_t pair_next;
    logic      res_valid_reg;
    vec4_t     res_reg;
    vec4_t     res_next;
    logic      sat_reg;
    logic      sat_next;
    logic      pair_load;
    logic      res_load;
    acc_t      rnd [4];
    acc_t      shr [4];

    assign res_load  = !res_valid_reg || out_ready;
    assign pair_load = !pair_valid_reg || res_load;
    assign in_ready  = pair_load;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 2; j++) begin
                pair_next[i][j] = pair_t'(in_prod[i][2*j]) + pair_t'(in_prod[i][2*j+1]);
            end
        end
    end

    // floor((sum + half) / 2^FRAC_BITS), clipped to the 32-bit signed range
    always_comb begin
        sat_next = 1'b0;
        for (int i = 0; i < 4; i++) begin
            rnd[i] = acc_t'(pair_reg[i][0]) + acc_t'(pair_reg[i][1]) + acc_t'(HALF_ACC);
            shr[i] = rnd[i] >>> FRAC_BITS;
            if (shr[i][ACC_W-1:FIX_W-1] == {(ACC_W-FIX_W+1){1'b0}} ||
                shr[i][ACC_W-1:FIX_W-1] == {(ACC_W-FIX_W+1){1'b1}}) begin
                res_next[i] = shr[i][FIX_W-1:0];
            end else if (shr[i][ACC_W-1]) begin
                res_next[i] = {1'b1, {(FIX_W-1){1'b0}}};
                sat_next    = 1'b1;
            end else begin
                res_next[i] = {1'b0, {(FIX_W-1){1'b1}}};
                sat_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (pair_load) begin
                pair_valid_reg <= in_valid;
            end
            if (res_load) begin
                res_valid_reg <= pair_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pair_load) begin
            pair_reg <= pair_next;
        end
        if (res_load) begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;
    assign out_sat   = sat_reg;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the 4x4 matrix transform engine: directed table, then random phases.
`timescale 1ns / 1ps

// How the run works
// -----------------
// A directed table comes first. Rows either write matrix registers or send one beat.
// Item rows carry a typed-in result where it is obvious by inspection (identity
// matrix, saturation at both rails, the half-LSB rounding case). Every other item,
// and all the random traffic that follows, is checked against the local predictor.
// The predictor keeps its own copy of the eight matrix words. It forms each
// component as an exact 66-bit sum of four products, rounds half up and clips to
// 32 bits. The copy is updated only when a write lands.
//
// Random traffic runs in phases. Each phase loads a fresh matrix from one style
// (small entries, full-range entries, all zero, all max, all min) plus one write to
// an index past the end, then streams beats. One phase runs with no idling on
// either side. Another opens with a long receiver hold-off so the pipeline backs up
// into s_ready.
//
// Inputs change on the falling edge; DUT outputs and handshakes are sampled on the
// rising edge, before any register in the DUT updates.
module tb_top;

    import m4xf_pkg::*;

    // Timing and pacing
    localparam int IDLE_PCT        = 15;   // chance in a hundred of an idle cycle per side
    localparam int HOLD_OFF_CYCLES = 60;   // receiver stall long enough to fill the pipeline
    localparam int TAIL_CYCLES     = 12;   // pipeline depth plus margin after the last result
    localparam int STALL_LIMIT     = 2000; // cycles with no beat and no write before giving up

    // Random phases
    localparam int N_PHASES   = 7;
    localparam int HOLD_PHASE = 1;
    localparam int CALM_PHASE = 5;

    // Command code the DUT treats as vec4
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // Matrix register indexes, plus two that fall past the end
    localparam logic [CFG_IDX_W-1:0] REG_R0_C01   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R0_C23   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R1_C01   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R1_C23   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R2_C01   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R2_C23   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_R3_C01   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_R3_C23   = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP  = 4'd15;

    // Handy Q16.16 values
    localparam logic [FIX_W-1:0] FX_ZERO    = 32'h0000_0000;
    localparam logic [FIX_W-1:0] FX_MAX     = 32'h7FFF_FFFF;
    localparam logic [FIX_W-1:0] FX_MIN     = 32'h8000_0000;
    localparam logic [FIX_W-1:0] FX_HALF    = 32'h0000_8000;
    localparam logic [FIX_W-1:0] FX_LSB     = 32'h0000_0001;
    localparam logic [FIX_W-1:0] FX_NEG_LSB = 32'hFFFF_FFFF;

    localparam cfg_word_t W_ALL_MAX = {FX_MAX, FX_MAX};
    localparam cfg_word_t W_ALL_MIN = {FX_MIN, FX_MIN};
    localparam cfg_word_t W_HALF_LO = {FX_ZERO, FX_HALF};   // 0.5 in the even column
    localparam cfg_word_t W_HALF_HI = {FX_HALF, FX_ZERO};   // 0.5 in the odd column

    // Clip rails for a rounded sum
    localparam acc_t SAT_HI = acc_t'(64'sd2147483647);
    localparam acc_t SAT_LO = acc_t'(-64'sd2147483648);

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [0:3][FIX_W-1:0]  elem;
    } xform_in_t;

    typedef struct packed {
        logic [0:3][FIX_W-1:0]  res;
        logic                   sat;
    } xform_out_t;

    typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_FILL} step_kind_e;

    typedef struct packed {
        step_kind_e             kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        cfg_word_t              word;
        xform_in_t              item;
        logic                   has_known;
        xform_out_t             known;
    } dir_step_t;

    typedef enum {MAT_SMALL, MAT_FULL, MAT_ZERO, MAT_MAX, MAT_MIN} mat_style_e;

    // Row builders for the directed table
    function automatic dir_step_t op_known(input logic [CMD_W-1:0] cmd,
                                           input logic [0:3][FIX_W-1:0] vin,
                                           input logic [0:3][FIX_W-1:0] vout,
                                           input logic sat);
        dir_step_t s;
        s = '0;
        s.kind      = STEP_ITEM;
        s.item.cmd  = cmd;
        s.item.elem = vin;
        s.has_known = 1'b1;
        s.known.res = vout;
        s.known.sat = sat;
        return s;
    endfunction

    function automatic dir_step_t op_checked(input logic [CMD_W-1:0] cmd,
                                             input logic [0:3][FIX_W-1:0] vin);
        dir_step_t s;
        s = '0;
        s.kind      = STEP_ITEM;
        s.item.cmd  = cmd;
        s.item.elem = vin;
        return s;
    endfunction

    function automatic dir_step_t reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input cfg_word_t word);
        dir_step_t s;
        s = '0;
        s.kind    = STEP_CFG;
        s.reg_idx = idx;
        s.word    = word;
        return s;
    endfunction

    function automatic dir_step_t reg_fill(input cfg_word_t word);
        dir_step_t s;
        s = '0;
        s.kind = STEP_FILL;
        s.word = word;
        return s;
    endfunction

    localparam int N_DIR = 37;

    localparam dir_step_t DIR_STEPS [N_DIR] = '{
        // identity after reset: every command except point passes the vector through
        op_known(CMD_VEC4, {ONE_FIX, 32'h0002_0000, 32'hFFFD_0000, FX_HALF},
                           {ONE_FIX, 32'h0002_0000, 32'hFFFD_0000, FX_HALF}, 1'b0),
        op_known(CMD_VEC4, {FX_MAX, FX_MIN, FX_LSB, FX_NEG_LSB},
                           {FX_MAX, FX_MIN, FX_LSB, FX_NEG_LSB}, 1'b0),
        // point ignores w and forces the fourth component to zero
        op_known(CMD_POINT, {32'h0003_0000, FX_NEG_LSB, FX_MAX, 32'h1234_5678},
                            {32'h0003_0000, FX_NEG_LSB, FX_MAX, FX_ZERO}, 1'b0),
        op_known(CMD_ROW, {FX_MIN, FX_MAX, FX_HALF, FX_NEG_LSB},
                          {FX_MIN, FX_MAX, FX_HALF, FX_NEG_LSB}, 1'b0),
        // unused command code behaves as vec4
        op_known(CMD_SPARE, {32'd1, 32'd2, 32'd3, 32'd4},
                            {32'd1, 32'd2, 32'd3, 32'd4}, 1'b0),
        // writes past the last register must leave the identity alone
        reg_write(REG_PAST_END, W_ALL_MAX),
        reg_write(REG_IDX_TOP, W_ALL_MIN),
        op_known(CMD_VEC4, {32'h0005_0000, 32'hFFFF_0000, 32'h0000_1234, FX_MIN},
                           {32'h0005_0000, 32'hFFFF_0000, 32'h0000_1234, FX_MIN}, 1'b0),
        // half identity: exact ties round toward plus infinity
        reg_write(REG_R0_C01, W_HALF_LO),
        reg_write(REG_R1_C01, W_HALF_HI),
        reg_write(REG_R2_C23, W_HALF_LO),
        reg_write(REG_R3_C23, W_HALF_HI),
        op_known(CMD_VEC4, {FX_LSB, FX_NEG_LSB, 32'd3, 32'hFFFF_FFFD},
                           {32'd1, FX_ZERO, 32'd2, FX_NEG_LSB}, 1'b0),
        op_known(CMD_POINT, {FX_LSB, FX_NEG_LSB, 32'd3, FX_MAX},
                            {32'd1, FX_ZERO, 32'd2, FX_ZERO}, 1'b0),
        op_known(CMD_ROW, {32'hFFFF_FFFD, 32'd3, FX_NEG_LSB, FX_LSB},
                          {FX_NEG_LSB, 32'd2, FX_ZERO, 32'd1}, 1'b0),
        // every entry at the positive rail
        reg_fill(W_ALL_MAX),
        op_known(CMD_VEC4, {FX_MAX, FX_MAX, FX_MAX, FX_MAX},
                           {FX_MAX, FX_MAX, FX_MAX, FX_MAX}, 1'b1),
        op_known(CMD_VEC4, {FX_MIN, FX_MIN, FX_MIN, FX_MIN},
                           {FX_MIN, FX_MIN, FX_MIN, FX_MIN}, 1'b1),
        op_known(CMD_POINT, {FX_MAX, FX_MAX, FX_MAX, FX_ZERO},
                            {FX_MAX, FX_MAX, FX_MAX, FX_ZERO}, 1'b1),
        op_known(CMD_ROW, {FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO},
                          {FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO}, 1'b0),
        // every entry at the negative rail
        reg_fill(W_ALL_MIN),
        op_known(CMD_ROW, {FX_MIN, FX_MIN, FX_MIN, FX_MIN},
                          {FX_MAX, FX_MAX, FX_MAX, FX_MAX}, 1'b1),
        op_known(CMD_POINT, {FX_MIN, FX_MIN, FX_MIN, FX_MIN},
                            {FX_MAX, FX_MAX, FX_MAX, FX_ZERO}, 1'b1),
        op_known(CMD_VEC4, {FX_MAX, FX_MAX, FX_MAX, FX_MAX},
                           {FX_MIN, FX_MIN, FX_MIN, FX_MIN}, 1'b1),
        // asymmetric matrix so vec4 and row differ; checked by the predictor
        reg_write(REG_R0_C01, {32'h0000_4000, 32'h0001_8000}),
        reg_write(REG_R0_C23, {32'hFFFF_0000, 32'h0002_0000}),
        reg_write(REG_R1_C01, {32'h0000_C000, 32'hFFFE_8000}),
        reg_write(REG_R1_C23, {32'h0003_0000, 32'h0000_0001}),
        reg_write(REG_R2_C01, {32'hFFFF_FFFF, 32'h0001_0000}),
        reg_write(REG_R2_C23, {32'h0000_8000, 32'hFFFF_8000}),
        reg_write(REG_R3_C01, {32'h7FFF_FFFF, 32'h0000_0000}),
        reg_write(REG_R3_C23, {32'h0001_0000, 32'h8000_0000}),
        op_checked(CMD_VEC4, {ONE_FIX, 32'h0002_0000, 32'hFFFF_8000, 32'd3}),
        op_checked(CMD_POINT, {ONE_FIX, 32'h0002_0000, 32'hFFFF_8000, FX_MAX}),
        op_checked(CMD_ROW, {ONE_FIX, 32'h0002_0000, 32'hFFFF_8000, 32'd3}),
        op_checked(CMD_SPARE, {32'h1234_5678, 32'h8765_4321, 32'h0F0F_F0F0, FX_HALF}),
        op_checked(CMD_ROW, {FX_LSB, FX_NEG_LSB, FX_HALF, 32'h0000_7FFF})
    };

    localparam mat_style_e PHASE_STYLE [N_PHASES] = '{
        MAT_SMALL, MAT_FULL, MAT_SMALL, MAT_ZERO, MAT_MAX, MAT_SMALL, MAT_MIN
    };

    // DUT connections
    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [CFG_IDX_W-1:0]           cfg_index;
    logic [CFG_W-1:0]               cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    logic [CMD_W-1:0]               s_command;
    logic signed [FIX_W-1:0]        s_elem_0;
    logic signed [FIX_W-1:0]        s_elem_1;
    logic signed [FIX_W-1:0]        s_elem_2;
    logic signed [FIX_W-1:0]        s_elem_3;
    logic                           m_valid;
    logic                           m_ready;
    logic signed [FIX_W-1:0]        m_res_0;
    logic signed [FIX_W-1:0]        m_res_1;
    logic signed [FIX_W-1:0]        m_res_2;
    logic signed [FIX_W-1:0]        m_res_3;
    logic                           m_saturated;

    // Predictor state and scoreboard
    cfg_word_t      mat_shadow [NUM_CFG];   // matrix as the predictor sees it
    xform_out_t     pending_xforms [$];     // results owed by the DUT, oldest first
    int             mismatch_count = 0;
    int             stall_cycles   = 0;
    logic           calm;                   // both sides run without idling
    logic           hold_off_req;           // receiver runs one long stall once set

    matrix4_transform_engine DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_elem_0    (s_elem_0),
        .s_elem_1    (s_elem_1),
        .s_elem_2    (s_elem_2),
        .s_elem_3    (s_elem_3),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_res_0     (m_res_0),
        .m_res_1     (m_res_1),
        .m_res_2     (m_res_2),
        .m_res_3     (m_res_3),
        .m_saturated (m_saturated)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Matrix entry (row, col) from the shadow copy: even column low half, odd column high.
    function automatic fix_t shadow_coef(input int row, input int col);
        cfg_word_t word;
        word = mat_shadow[row * 2 + col / 2];
        return (col % 2 == 1) ? fix_t'(word[CFG_W-1:FIX_W]) : fix_t'(word[FIX_W-1:0]);
    endfunction

    // Expected result of one beat under the current matrix.
    function automatic xform_out_t predict_xform(input xform_in_t beat);
        xform_out_t o;
        fix_t       vec [4];
        fix_t       coef;
        prod_t      prod;
        acc_t       acc;
        o = '0;
        for (int k = 0; k < 4; k++) begin
            vec[k] = beat.elem[k];
        end
        // point swaps w for 1.0
        if (beat.cmd == CMD_POINT) begin
            vec[3] = ONE_FIX;
        end
        for (int i = 0; i < 4; i++) begin
            if (beat.cmd == CMD_POINT && i == 3) begin
                o.res[i] = '0;
            end else begin
                acc = '0;
                for (int k = 0; k < 4; k++) begin
                    coef = (beat.cmd == CMD_ROW) ? shadow_coef(k, i) : shadow_coef(i, k);
                    prod = coef * vec[k];
                    acc  = acc + prod;
                end
                // floor of (sum + half) is round half up
                acc = acc + acc_t'(HALF_ACC);
                acc = acc >>> FRAC_BITS;
                if (acc > SAT_HI) begin
                    acc   = SAT_HI;
                    o.sat = 1'b1;
                end else if (acc < SAT_LO) begin
                    acc   = SAT_LO;
                    o.sat = 1'b1;
                end
                o.res[i] = acc[FIX_W-1:0];
            end
        end
        return o;
    endfunction

    function automatic logic [FIX_W-1:0] rand_entry(input mat_style_e style);
        logic [FIX_W-1:0] u;
        case (style)
            MAT_SMALL: begin
                // roughly -4.0 .. +4.0 with a random fraction
                u = $urandom_range(0, 32'h0007_FFFF);
                return u - 32'h0004_0000;
            end
            MAT_FULL: return $urandom;
            MAT_MAX:  return FX_MAX;
            MAT_MIN:  return FX_MIN;
            default:  return FX_ZERO;
        endcase
    endfunction

    function automatic logic [FIX_W-1:0] rand_elem();
        logic [FIX_W-1:0] u;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            // about -16.0 .. +16.0, keeps most sums away from the rails
            u = $urandom_range(0, 32'h001F_FFFF);
            return u - 32'h0010_0000;
        end else if (pick < 80) begin
            return $urandom;
        end
        case ($urandom_range(0, 6))
            0:       return FX_MAX;
            1:       return FX_MIN;
            2:       return FX_LSB;
            3:       return FX_NEG_LSB;
            4:       return FX_HALF;
            5:       return ONE_FIX;
            default: return FX_ZERO;
        endcase
    endfunction

    function automatic xform_in_t rand_item();
        xform_in_t b;
        b.cmd = CMD_W'($urandom_range(0, 3));
        for (int k = 0; k < 4; k++) begin
            b.elem[k] = rand_elem();
        end
        return b;
    endfunction

    // Offer one beat; hold it until accepted, then log what the DUT owes for it.
    // Called and returns on a falling edge, leaving s_valid high for the caller to decide.
    task automatic send_beat(input xform_in_t beat, input logic use_known,
                             input xform_out_t known);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_command = beat.cmd;
        s_elem_0  = beat.elem[0];
        s_elem_1  = beat.elem[1];
        s_elem_2  = beat.elem[2];
        s_elem_3  = beat.elem[3];
        s_valid   = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_xforms.push_back(use_known ? known : predict_xform(beat));
        @(negedge aclk);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain_pipeline();
        s_valid = 1'b0;
        while (pending_xforms.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // One register write; the shadow follows once the write edge has passed.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t word);
        cfg_index = idx;
        cfg_wdata = word;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        // indexes past the last register are dropped by the DUT
        if (idx < NUM_CFG) begin
            mat_shadow[idx] = word;
        end
    endtask

    // Receiver: random back-pressure, a calm stretch, and one long hold-off on request.
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each result beat with the oldest one owed.
    always @(posedge aclk) begin
        xform_out_t got;
        xform_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got.res = {m_res_0, m_res_1, m_res_2, m_res_3};
            got.sat = m_saturated;
            if (pending_xforms.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with none owed, expected nothing, got %h",
                         $time, got);
            end else begin
                want = pending_xforms.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got.res[i] !== want.res[i]) begin
                        mismatch_count++;
                        $display("%0t: res_%0d expected %h, got %h",
                                 $time, i, want.res[i], got.res[i]);
                    end
                end
                if (got.sat !== want.sat) begin
                    mismatch_count++;
                    $display("%0t: saturated expected %b, got %b", $time, want.sat, got.sat);
                end
            end
        end
    end

    // Watchdog: any beat or write counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        dir_step_t  st;
        mat_style_e style;
        int         n_items;

        // known values on every input from time zero
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_command    = CMD_VEC4;
        s_elem_0     = '0;
        s_elem_1     = '0;
        s_elem_2     = '0;
        s_elem_3     = '0;
        calm         = 1'b0;
        hold_off_req = 1'b0;

        // shadow matches the identity loaded by reset
        for (int r = 0; r < NUM_CFG; r++) begin
            mat_shadow[r] = '0;
        end
        mat_shadow[REG_R0_C01] = {FX_ZERO, ONE_FIX};
        mat_shadow[REG_R1_C01] = {ONE_FIX, FX_ZERO};
        mat_shadow[REG_R2_C23] = {FX_ZERO, ONE_FIX};
        mat_shadow[REG_R3_C23] = {ONE_FIX, FX_ZERO};

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        for (int n = 0; n < N_DIR; n++) begin
            st = DIR_STEPS[n];
            case (st.kind)
                STEP_ITEM: send_beat(st.item, st.has_known, st.known);
                STEP_CFG: begin
                    drain_pipeline();
                    cfg_write(st.reg_idx, st.word);
                end
                default: begin
                    drain_pipeline();
                    for (int r = 0; r < NUM_CFG; r++) begin
                        cfg_write(CFG_IDX_W'(r), st.word);
                    end
                end
            endcase
        end

        // random phases, each with a fresh matrix
        for (int ph = 0; ph < N_PHASES; ph++) begin
            style   = PHASE_STYLE[ph];
            n_items = (style == MAT_SMALL || style == MAT_FULL) ? 110 : 50;
            drain_pipeline();
            calm = 1'b0;
            for (int r = 0; r < NUM_CFG; r++) begin
                cfg_write(CFG_IDX_W'(r), {rand_entry(style), rand_entry(style)});
            end
            // stray write past the register file
            cfg_write(CFG_IDX_W'($urandom_range(NUM_CFG, (1 << CFG_IDX_W) - 1)),
                      {$urandom, $urandom});
            calm = (ph == CALM_PHASE);
            if (ph == HOLD_PHASE) begin
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < n_items; n++) begin
                send_beat(rand_item(), 1'b0, '0);
            end
        end

        // let the last results out, then watch for strays
        drain_pipeline();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
hdl/m4xf_pkg.sv
hdl/m4xf_operand_sel.sv
hdl/m4xf_mul_array.sv
hdl/m4xf_reduce.sv
hdl/matrix4_transform_engine.sv
tb/tb_top.sv
